// ===== rtl/shm_pkg.sv =====
package shm_pkg;

  localparam int SERVICES = 8;
  localparam int IDX_W    = (SERVICES > 1) ? $clog2(SERVICES) : 1;

  localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

  localparam logic [1:0] CMD_INIT  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_BEAT  = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam logic [1:0] HS_NOT_STARTED = 2'd0;
  localparam logic [1:0] HS_STALE       = 2'd1;
  localparam logic [1:0] HS_HEALTHY     = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  service_index;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic        accepted;
    logic [1:0]  health_state;
    logic [31:0] start_time_out;
    logic [31:0] last_beat_out;
    logic [31:0] beat_count_out;
  } out_t;

  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

endpackage

// ===== rtl/shm_ctrl.sv =====
module shm_ctrl
  import shm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t dp_cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_ready    = (state_r == ST_IDLE);
  assign out_valid   = (state_r == ST_RESP);
  assign dp_cmd.load = in_valid && in_ready;
  assign dp_cmd.exec = (state_r == ST_EXEC);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/shm_dp.sv =====
module shm_dp
  import shm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     dp_cmd,
  input  in_t         in_data,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  output out_t        out_data
);

  in_t         req_r;
  out_t        res_r;
  out_t        res_nxt;
  logic [31:0] timeout_r;
  logic        armed_r;
  logic        armed_nxt;

  logic [SERVICES-1:0] started_r;
  logic [SERVICES-1:0] started_nxt;
  logic [31:0]         start_time_r [SERVICES];
  logic [31:0]         last_beat_r  [SERVICES];
  logic [31:0]         count_r      [SERVICES];

  logic [IDX_W-1:0] idx;
  logic             in_range;
  logic             hit_started;
  logic [31:0]      elapsed;
  logic             wr_start;
  logic             wr_beat;

  assign idx         = req_r.service_index[IDX_W-1:0];
  assign in_range    = (req_r.service_index < 8'(SERVICES));
  assign hit_started = started_r[idx];
  assign elapsed     = req_r.now_ms - last_beat_r[idx];

  always_comb begin
    res_nxt     = '0;
    armed_nxt   = armed_r;
    started_nxt = started_r;
    wr_start    = 1'b0;
    wr_beat     = 1'b0;
    if (req_r.command == CMD_INIT) begin
      armed_nxt        = 1'b1;
      started_nxt      = '0;
      res_nxt.accepted = 1'b1;
    end else if (armed_r && in_range) begin
      unique case (req_r.command)
        CMD_START: begin
          res_nxt.accepted = 1'b1;
          if (!hit_started) begin
            wr_start         = 1'b1;
            started_nxt[idx] = 1'b1;
          end
        end
        CMD_BEAT: begin
          if (hit_started) begin
            wr_beat          = 1'b1;
            res_nxt.accepted = 1'b1;
          end
        end
        default: begin
          res_nxt.accepted = 1'b1;
          if (!hit_started) begin
            res_nxt.health_state = HS_NOT_STARTED;
          end else if (elapsed >= timeout_r) begin
            res_nxt.health_state = HS_STALE;
          end else begin
            res_nxt.health_state = HS_HEALTHY;
          end
          // results for entries that are not started report zeros
          if (hit_started) begin
            res_nxt.start_time_out = start_time_r[idx];
            res_nxt.last_beat_out  = last_beat_r[idx];
            res_nxt.beat_count_out = count_r[idx];
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
      armed_r   <= 1'b0;
      started_r <= '0;
    end else begin
      if (cfg_we) timeout_r <= cfg_data;
      if (dp_cmd.exec) begin
        armed_r   <= armed_nxt;
        started_r <= started_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) req_r <= in_data;
    if (dp_cmd.exec) begin
      res_r <= res_nxt;
      if (wr_start) begin
        start_time_r[idx] <= req_r.now_ms;
        last_beat_r[idx]  <= req_r.now_ms;
        count_r[idx]      <= '0;
      end else if (wr_beat) begin
        last_beat_r[idx] <= req_r.now_ms;
        count_r[idx]     <= count_r[idx] + 32'd1;
      end
    end
  end

  assign out_data = res_r;

endmodule

// ===== rtl/service_heartbeat_monitor.sv =====
// Channel | Ports                          | Moves
// input   | in_valid, in_ready, in_data    | one command per transfer
// result  | out_valid, out_ready, out_data | one result per command
// config  | cfg_we, cfg_data               | timeout write, no wait
//
// Each command passes through capture, table update/lookup and result, in that order.
// One command in flight; in_ready stays low until its result is transferred.
// Result holds in its output register while out_ready is low.
// Reset (rst_n, sync) disarms the block, marks all entries not started, timeout = 1000.
module service_heartbeat_monitor
  import shm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data
);

  dp_cmd_t dp_cmd;

  shm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_cmd    (dp_cmd)
  );

  shm_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .dp_cmd   (dp_cmd),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .out_data (out_data)
  );

endmodule
